### sv/wavp_pkg.sv
// Shared types, codes and constants for the WAV header parser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package wavp_pkg;

  typedef logic [3:0] phase_t;

  localparam phase_t P_IDLE      = 4'd0;
  localparam phase_t P_RIFF_HDR  = 4'd1;
  localparam phase_t P_RIFF_SKIP = 4'd2;
  localparam phase_t P_WAVE      = 4'd3;
  localparam phase_t P_FMT_HDR   = 4'd4;
  localparam phase_t P_FMT_SKIP  = 4'd5;
  localparam phase_t P_TAG       = 4'd6;
  localparam phase_t P_CHAN      = 4'd7;
  localparam phase_t P_RATE      = 4'd8;
  localparam phase_t P_PAD       = 4'd9;
  localparam phase_t P_BITS      = 4'd10;
  localparam phase_t P_DATA_HDR  = 4'd11;
  localparam phase_t P_DATA_SKIP = 4'd12;
  localparam phase_t P_DATA      = 4'd13;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_BAD_ID    = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_BAD_SHAPE = 3'd4;

  localparam logic [1:0] FMT_MONO8    = 2'd0;
  localparam logic [1:0] FMT_MONO16   = 2'd1;
  localparam logic [1:0] FMT_STEREO8  = 2'd2;
  localparam logic [1:0] FMT_STEREO16 = 2'd3;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [15:0] TAG_PCM = 16'h0001;
  localparam logic [2:0]  PAD_LAST = 3'd5;

  localparam logic [2:0] CNT_WORD_LAST = 3'd3;
  localparam logic [2:0] CNT_HALF_LAST = 3'd1;
  localparam logic [2:0] CNT_HDR_LAST  = 3'd7;

  localparam logic [15:0] CHAN_MONO   = 16'd1;
  localparam logic [15:0] CHAN_STEREO = 16'd2;
  localparam logic [15:0] BITS_8      = 16'd8;
  localparam logic [15:0] BITS_16     = 16'd16;

  localparam int OUT_TDATA_W = 80;
  localparam int STATUS_LSB  = 0;
  localparam int FMT_LSB     = 3;
  localparam int RATE_LSB    = 5;
  localparam int SIZE_LSB    = 37;
  localparam int SAMPLE_LSB  = 69;
  localparam int PAD_LSB     = 77;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_count;
    logic [31:0] shift_word;
    logic [31:0] skip_left;
    logic [15:0] chan_count;
    logic [31:0] rate_reg;
    logic [15:0] bits_reg;
    logic [1:0]  format_reg;
    logic [31:0] data_left;
  } wavp_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [1:0]  fmt_code;
    logic [31:0] rate;
    logic [31:0] payload_size;
    logic [7:0]  sample_byte;
    logic        end_of_data;
  } wavp_result_t;

endpackage

`default_nettype wire

### sv/wav_header_parser_core.sv
// Top level of the WAV header parser: input register, parse state and result buffer.
// Depends on wavp_pkg, wavp_step and wavp_out_buf.
//
// The file arrives one byte per transfer on the in_ channel; in_tuser marks the
// first byte of a file and in_tlast its final byte. The out_ channel carries a
// header report, a data byte or an error report, with the kind on out_tuser and
// the end of the audio data on out_tlast. Bytes of the headers and of skipped
// chunks give no transfer on the out_ channel.
// A byte is held in an input register, runs through the parse logic and lands in
// the result register, or in the skid stage while the result register is still
// full; a result is presented from the result register until out_tready takes it.
// One byte is taken in every cycle while the receiver keeps out_tready high.
// When the receiver stalls, one more result is caught in the skid stage and
// in_tready then falls until the result register drains.
// Synchronous reset returns the parser to idle and empties both buffers; bytes
// are ignored until one marked as first arrives.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_core
  import wavp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // byte_in[7:0]
  input  wire logic        in_tuser,   // first
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // status, fmt_code, rate, payload_size, sample_byte, zeros
  output logic [1:0]       out_tuser,  // kind
  output logic             out_tlast
);

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_first_r;
  logic         in_last_r;
  wavp_state_t  st_r;
  wavp_state_t  st_nxt;
  logic         produced;
  wavp_result_t res;
  wavp_result_t dn_res;
  logic         buf_ready;
  logic         step_en;

  assign step_en   = in_valid_r && buf_ready;
  assign in_tready = !in_valid_r || buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  wavp_step u_step (
    .st       (st_r),
    .byte_in  (in_byte_r),
    .first    (in_first_r),
    .last     (in_last_r),
    .st_nxt   (st_nxt),
    .produced (produced),
    .res      (res)
  );

  wavp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (step_en && produced),
    .up_ready (buf_ready),
    .up_res   (res),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (dn_res)
  );

  assign out_tdata = {3'b000, dn_res.sample_byte, dn_res.payload_size, dn_res.rate,
                      dn_res.fmt_code, dn_res.status};
  assign out_tuser = dn_res.kind;
  assign out_tlast = dn_res.end_of_data;

endmodule

`default_nettype wire

### sv/wavp_step.sv
// Combinational next-state and result logic for one byte of the file.
// Depends on wavp_pkg for the phase codes, identifiers and structs.
`timescale 1ns / 1ps
`default_nettype none

module wavp_step
  import wavp_pkg::*;
(
  input  wire wavp_state_t  st,
  input  wire logic [7:0]   byte_in,
  input  wire logic         first,
  input  wire logic         last,
  output wavp_state_t       st_nxt,
  output logic              produced,
  output wavp_result_t      res
);

  wavp_state_t  cur;
  wavp_state_t  nxt;
  wavp_result_t r;
  logic         prod;
  logic         active;
  logic [2:0]   n;
  logic [31:0]  sh_b;
  logic [31:0]  sk_b;
  logic [31:0]  target;
  logic         hdr_done;
  logic         hdr_match;
  logic [31:0]  dec_skip;
  logic [31:0]  dec_data;
  logic [15:0]  bits_new;
  logic [15:0]  chan_new;
  logic         eod;

  always_comb begin
    cur = st;
    if (first) begin
      cur = '0;
      cur.phase = P_RIFF_HDR;
    end
    active = first || (st.phase != P_IDLE);
    n = cur.field_count;
    sh_b = {byte_in, cur.shift_word[31:8]};
    sk_b = {byte_in, cur.skip_left[31:8]};
    dec_skip = cur.skip_left - 32'd1;
    dec_data = cur.data_left - 32'd1;
    chan_new = {byte_in, cur.chan_count[15:8]};
    bits_new = {byte_in, cur.bits_reg[15:8]};
    eod = (dec_data == 32'd0) || last;
    case (cur.phase)
      P_RIFF_HDR: target = ID_RIFF;
      P_FMT_HDR:  target = ID_FMT;
      default:    target = ID_DATA;
    endcase
    hdr_done = (n == CNT_HDR_LAST);
    hdr_match = hdr_done && (cur.shift_word == target);

    nxt = cur;
    r = '0;
    prod = 1'b0;

    case (cur.phase)
      P_RIFF_HDR, P_FMT_HDR, P_DATA_HDR: begin
        if (!n[2]) begin
          nxt.shift_word = sh_b;
        end else begin
          nxt.skip_left = sk_b;
        end
        nxt.field_count = n + 3'd1;
        if (hdr_match) begin
          case (cur.phase)
            P_RIFF_HDR: nxt.phase = P_WAVE;
            P_FMT_HDR:  nxt.phase = P_TAG;
            default: begin
              nxt.data_left = sk_b;
              r.kind = KIND_HEADER;
              r.status = ST_OK;
              r.fmt_code = cur.format_reg;
              r.rate = cur.rate_reg;
              r.payload_size = sk_b;
              prod = 1'b1;
              nxt.phase = (sk_b != 32'd0) ? P_DATA : P_IDLE;
            end
          endcase
        end else if (hdr_done && (sk_b != 32'd0)) begin
          case (cur.phase)
            P_RIFF_HDR: nxt.phase = P_RIFF_SKIP;
            P_FMT_HDR:  nxt.phase = P_FMT_SKIP;
            default:    nxt.phase = P_DATA_SKIP;
          endcase
        end
      end
      P_RIFF_SKIP, P_FMT_SKIP, P_DATA_SKIP: begin
        nxt.skip_left = dec_skip;
        if (dec_skip == 32'd0) begin
          case (cur.phase)
            P_RIFF_SKIP: nxt.phase = P_RIFF_HDR;
            P_FMT_SKIP:  nxt.phase = P_FMT_HDR;
            default:     nxt.phase = P_DATA_HDR;
          endcase
        end
      end
      P_WAVE: begin
        nxt.shift_word = sh_b;
        nxt.field_count = n + 3'd1;
        if (n == CNT_WORD_LAST) begin
          nxt.field_count = 3'd0;
          if (sh_b == ID_WAVE) begin
            nxt.phase = P_FMT_HDR;
          end else begin
            r.kind = KIND_ERROR;
            r.status = ST_BAD_ID;
            prod = 1'b1;
            nxt.phase = P_IDLE;
          end
        end
      end
      P_TAG: begin
        nxt.shift_word = sh_b;
        nxt.field_count = n + 3'd1;
        if (n == CNT_HALF_LAST) begin
          nxt.field_count = 3'd0;
          if (sh_b[31:16] == TAG_PCM) begin
            nxt.phase = P_CHAN;
          end else begin
            r.kind = KIND_ERROR;
            r.status = ST_NOT_PCM;
            prod = 1'b1;
            nxt.phase = P_IDLE;
          end
        end
      end
      P_CHAN: begin
        nxt.chan_count = chan_new;
        nxt.field_count = n + 3'd1;
        if (n == CNT_HALF_LAST) begin
          nxt.field_count = 3'd0;
          nxt.phase = P_RATE;
        end
      end
      P_RATE: begin
        nxt.rate_reg = {byte_in, cur.rate_reg[31:8]};
        nxt.field_count = n + 3'd1;
        if (n == CNT_WORD_LAST) begin
          nxt.field_count = 3'd0;
          nxt.phase = P_PAD;
        end
      end
      P_PAD: begin
        nxt.field_count = n + 3'd1;
        if (n >= PAD_LAST) begin
          nxt.field_count = 3'd0;
          nxt.phase = P_BITS;
        end
      end
      P_BITS: begin
        nxt.bits_reg = bits_new;
        nxt.field_count = n + 3'd1;
        if (n == CNT_HALF_LAST) begin
          nxt.field_count = 3'd0;
          nxt.phase = P_DATA_HDR;
          if (cur.chan_count == CHAN_MONO && bits_new == BITS_8) begin
            nxt.format_reg = FMT_MONO8;
          end else if (cur.chan_count == CHAN_MONO && bits_new == BITS_16) begin
            nxt.format_reg = FMT_MONO16;
          end else if (cur.chan_count == CHAN_STEREO && bits_new == BITS_8) begin
            nxt.format_reg = FMT_STEREO8;
          end else if (cur.chan_count == CHAN_STEREO && bits_new == BITS_16) begin
            nxt.format_reg = FMT_STEREO16;
          end else begin
            r.kind = KIND_ERROR;
            r.status = ST_BAD_SHAPE;
            prod = 1'b1;
            nxt.phase = P_IDLE;
          end
        end
      end
      P_DATA: begin
        nxt.data_left = dec_data;
        r.kind = KIND_DATA;
        r.sample_byte = byte_in;
        r.end_of_data = eod;
        prod = 1'b1;
        if (eod) begin
          nxt.phase = P_IDLE;
        end
      end
      default: begin
        nxt.phase = P_IDLE;
      end
    endcase

    if (last) begin
      if (!prod && nxt.phase != P_IDLE) begin
        r = '0;
        r.kind = KIND_ERROR;
        r.status = ST_TRUNC;
        prod = 1'b1;
      end
      nxt.phase = P_IDLE;
    end

    if (!active) begin
      nxt = st;
      prod = 1'b0;
    end
    st_nxt = nxt;
    produced = prod;
    res = r;
  end

endmodule

`default_nettype wire

### sv/wavp_out_buf.sv
// Result register with a skid stage so the parser keeps taking bytes while a result waits.
// Depends on wavp_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module wavp_out_buf
  import wavp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire wavp_result_t up_res,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output wavp_result_t      dn_res
);

  logic         main_valid_r;
  logic         skid_valid_r;
  wavp_result_t main_r;
  wavp_result_t skid_r;
  logic         main_free;

  assign up_ready  = !skid_valid_r;
  assign main_free = !main_valid_r || dn_ready;
  assign dn_valid  = main_valid_r;
  assign dn_res    = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= up_valid;
      end
    end else if (up_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (up_valid) begin
        main_r <= up_res;
      end
    end else if (up_valid && !skid_valid_r) begin
      skid_r <= up_res;
    end
  end

endmodule

`default_nettype wire

### sv/wavp_checker.sv
// Port-level checks of the WAV header parser, bound to the top level.
// Depends on wavp_pkg for the result kinds and the field positions in out_tdata.
`timescale 1ns / 1ps
`default_nettype none

module wavp_checker
  import wavp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result channel valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  a_report_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> !out_tlast
      && out_tdata[OUT_TDATA_W-1:SAMPLE_LSB] == '0)
    else $error("report carries data byte fields");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |-> out_tdata[SAMPLE_LSB-1:0] == '0)
    else $error("data byte carries report fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR |-> out_tdata[STATUS_LSB+2:STATUS_LSB] != ST_OK
      && out_tdata[SAMPLE_LSB-1:FMT_LSB] == '0)
    else $error("error report malformed");

endmodule

bind wav_header_parser_core wavp_checker u_wavp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
